>>> sv/dttt_pkg.sv
`default_nettype none

package dttt_pkg;

    localparam int SLOTS       = 20;
    localparam int FRAME_MS    = 20;
    localparam int MAX_RESULTS = 60;
    localparam int MAX_FIRES   = MAX_RESULTS / 3;

    localparam int TRK_W  = 16;
    localparam int DLY_W  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FIRE_W = $clog2(MAX_FIRES + 1);

    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_TICK     = 1'b1;

    localparam logic [0:0] CFG_PLAY_CODE = 1'b0;
    localparam logic [0:0] CFG_RAMP_MS   = 1'b1;

    localparam logic signed [7:0] GAIN_MUTE = -8'sd70;
    localparam logic signed [7:0] GAIN_FULL = 8'sd0;

    typedef enum logic [1:0] {
        KIND_GAIN,
        KIND_PLAY,
        KIND_FADE,
        KIND_STATUS
    } t_kind;

    typedef struct packed {
        logic              action;
        logic [TRK_W-1:0]  track;
        logic [DLY_W-1:0]  delay_ms;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [TRK_W-1:0]  track_out;
        logic signed [7:0] gain;
        logic [7:0]        code;
        logic [15:0]       fade_ms;
        logic              accepted;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        TBL_NOP,
        TBL_STORE,
        TBL_FREE,
        TBL_DEC
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op           op;
        logic [IDX_W-1:0]  idx;
        logic [DLY_W-1:0]  frames;
        logic [TRK_W-1:0]  track;
    } t_tbl_cmd;

    typedef struct packed {
        logic              busy;
        logic              zero;
        logic [TRK_W-1:0]  track;
    } t_tbl_rd;

endpackage

`default_nettype wire

>>> sv/delayed_track_trigger_table.sv
// Table of pending delayed track starts with one item handled at a time; o_in_ready is high
// only while the sequencer is idle. A schedule beat turns delay_ms into a frame count
// (delay_ms / FRAME_MS by a reciprocal multiply, registered in dttt_div), then searches for
// the lowest free slot at one slot per cycle and returns one status beat, which waits while
// the output side stalls. A tick beat walks all SLOTS slots at one cycle per slot for slots
// that do not fire; a slot that fires holds the walk while its beats go into the output
// register, and output stalls hold it further. A tick with nothing due gives no beat. The
// output register lets a finished beat wait while the walk goes on to the next slot. The
// table is empty after reset, with no clearing pass. Configuration writes are taken at any
// time and must arrive only while the block is idle.
`default_nettype none

module delayed_track_trigger_table
    import dttt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FIND,
        S_STATUS,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        BEAT_FADE_PREV,
        BEAT_GAIN,
        BEAT_PLAY
    } t_beat;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state             r_state,      n_state;
    t_beat              r_beat,       n_beat;
    logic [IDX_W-1:0]   r_idx,        n_idx;
    logic [FIRE_W-1:0]  r_fires,      n_fires;
    logic               r_pend,       n_pend;
    logic [TRK_W-1:0]   r_pend_track, n_pend_track;
    logic [TRK_W-1:0]   r_cur_track,  n_cur_track;
    logic [TRK_W-1:0]   r_sched_track, n_sched_track;
    logic               r_acc,        n_acc;
    logic               r_out_valid,  n_out_valid;
    t_out_item          r_out,        n_out;

    logic [7:0]         r_play_code;
    logic [15:0]        r_ramp_ms;

    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [DLY_W-1:0]   div_quot;
    t_tbl_cmd           tbl_cmd;
    t_tbl_rd            tbl_rd;

    dttt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_item.delay_ms),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    dttt_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rd    (tbl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_code <= '0;
            r_ramp_ms   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PLAY_CODE: r_play_code <= i_cfg_data[7:0];
                CFG_RAMP_MS:   r_ramp_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_beat        = r_beat;
        n_idx         = r_idx;
        n_fires       = r_fires;
        n_pend        = r_pend;
        n_pend_track  = r_pend_track;
        n_cur_track   = r_cur_track;
        n_sched_track = r_sched_track;
        n_acc         = r_acc;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        div_start     = 1'b0;
        tbl_cmd.op     = TBL_NOP;
        tbl_cmd.idx    = r_idx;
        tbl_cmd.frames = div_quot;
        tbl_cmd.track  = r_sched_track;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx = '0;
                    if (i_in_item.action == ACT_TICK) begin
                        n_fires = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end else begin
                        div_start     = 1'b1;
                        n_sched_track = i_in_item.track;
                        n_state       = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (!tbl_rd.busy) begin
                    tbl_cmd.op = TBL_STORE;
                    n_acc      = 1'b1;
                    n_state    = S_STATUS;
                end else if (r_idx == LAST_IDX) begin
                    n_acc   = 1'b0;
                    n_state = S_STATUS;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_STATUS;
                    n_out.track_out   = r_sched_track;
                    n_out.gain        = GAIN_FULL;
                    n_out.code        = '0;
                    n_out.fade_ms     = '0;
                    n_out.accepted    = r_acc;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SCAN: begin
                if (tbl_rd.busy && tbl_rd.zero && (r_fires != FIRE_W'(MAX_FIRES))) begin
                    tbl_cmd.op  = TBL_FREE;
                    n_cur_track = tbl_rd.track;
                    n_fires     = r_fires + FIRE_W'(1);
                    n_beat      = r_pend ? BEAT_FADE_PREV : BEAT_GAIN;
                    n_state     = S_EMIT;
                end else begin
                    if (tbl_rd.busy && !tbl_rd.zero) begin
                        tbl_cmd.op = TBL_DEC;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.gain     = GAIN_FULL;
                    n_out.code     = '0;
                    n_out.fade_ms  = '0;
                    n_out.accepted = 1'b0;
                    n_out.last     = 1'b0;
                    unique case (r_beat)
                        BEAT_FADE_PREV: begin
                            n_out.kind      = KIND_FADE;
                            n_out.track_out = r_pend_track;
                            n_out.fade_ms   = r_ramp_ms;
                            n_beat          = BEAT_GAIN;
                        end
                        BEAT_GAIN: begin
                            n_out.kind      = KIND_GAIN;
                            n_out.track_out = r_cur_track;
                            n_out.gain      = GAIN_MUTE;
                            n_beat          = BEAT_PLAY;
                        end
                        BEAT_PLAY: begin
                            n_out.kind      = KIND_PLAY;
                            n_out.track_out = r_cur_track;
                            n_out.code      = r_play_code;
                            n_pend          = 1'b1;
                            n_pend_track    = r_cur_track;
                            if (r_idx == LAST_IDX) begin
                                n_state = S_FLUSH;
                            end else begin
                                n_idx   = r_idx + IDX_W'(1);
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !i_out_ready;
                            n_beat      = BEAT_GAIN;
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_FADE;
                    n_out.track_out = r_pend_track;
                    n_out.gain      = GAIN_FULL;
                    n_out.code      = '0;
                    n_out.fade_ms   = r_ramp_ms;
                    n_out.accepted  = 1'b0;
                    n_out.last      = 1'b1;
                    n_pend          = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_fires     <= '0;
            r_idx       <= '0;
            r_beat      <= BEAT_GAIN;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_fires     <= n_fires;
            r_idx       <= n_idx;
            r_beat      <= n_beat;
        end
        r_pend_track  <= n_pend_track;
        r_cur_track   <= n_cur_track;
        r_sched_track <= n_sched_track;
        r_acc         <= n_acc;
        r_out         <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("pending fade left over in idle");

    a_fires_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fires <= FIRE_W'(MAX_FIRES))
        else $error("fire count above result capacity");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind == KIND_STATUS)) |-> o_out_item.last)
        else $error("status beat without last");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

endmodule

`default_nettype wire

>>> sv/dttt_div.sv
`default_nettype none

module dttt_div
    import dttt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DLY_W-1:0]  i_dividend,
    output logic                   o_done,
    output logic [DLY_W-1:0]       o_quot
);

    localparam int DIV_SHIFT = DLY_W + $clog2(FRAME_MS);
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + FRAME_MS - 1) / FRAME_MS;
    localparam int MUL_W     = DLY_W + 1;
    localparam int PROD_W    = DLY_W + MUL_W;

    localparam logic [MUL_W-1:0] RECIP = MUL_W'(DIV_MULT);

    logic              r_done;
    logic [DLY_W-1:0]  r_q;
    logic [PROD_W-1:0] prod;

    always_comb begin
        prod = {{MUL_W{1'b0}}, i_dividend} * {{DLY_W{1'b0}}, RECIP};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_q <= DLY_W'(prod >> DIV_SHIFT);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

>>> sv/dttt_table.sv
`default_nettype none

module dttt_table
    import dttt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_tbl_cmd  i_cmd,
    output t_tbl_rd        o_rd
);

    logic [SLOTS-1:0]  r_busy;
    logic [DLY_W-1:0]  r_frames [SLOTS];
    logic [TRK_W-1:0]  r_track  [SLOTS];

    always_comb begin
        o_rd.busy  = r_busy[i_cmd.idx];
        o_rd.zero  = (r_frames[i_cmd.idx] == '0);
        o_rd.track = r_track[i_cmd.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            unique case (i_cmd.op) inside
                TBL_STORE:        r_busy[i_cmd.idx] <= 1'b1;
                TBL_FREE:         r_busy[i_cmd.idx] <= 1'b0;
                TBL_NOP, TBL_DEC: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op) inside
            TBL_STORE: begin
                r_frames[i_cmd.idx] <= i_cmd.frames;
                r_track[i_cmd.idx]  <= i_cmd.track;
            end
            TBL_DEC:   r_frames[i_cmd.idx] <= r_frames[i_cmd.idx] - DLY_W'(1);
            TBL_NOP, TBL_FREE: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> test/delayed_track_trigger_table_test.sv
module delayed_track_trigger_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dttt_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 4 * SLOTS + 16;
    localparam int DRAIN_LIMIT  = 200_000;
    localparam int PHASE_ITEMS  = 60;
    localparam int QUIET_ITEMS  = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    delayed_track_trigger_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    typedef struct {
        t_in_item  item;
        int        reps;
        int        typed;
        t_out_item want;
    } t_plan_row;

    logic        slot_used [SLOTS];
    logic [15:0] slot_wait [SLOTS];
    logic [15:0] slot_trk  [SLOTS];
    logic [7:0]  cur_code = 8'h00;
    logic [15:0] cur_ramp = 16'h0000;

    t_out_item step_beats [$];
    t_out_item due_q [$];
    t_plan_row plan [$];
    t_out_item head_beat;
    bit        failed = 1'b0;
    bit        quiet = 1'b0;
    int        stall_left = 0;
    int        cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[delayed_track_trigger_table] ERROR");
        $finish;
    end

    function automatic t_out_item beat_of(t_kind k, logic [15:0] trk, logic signed [7:0] g,
                                          logic [7:0] c, logic [15:0] f, logic acc,
                                          logic lst);
        t_out_item b;
        b.kind      = k;
        b.track_out = trk;
        b.gain      = g;
        b.code      = c;
        b.fade_ms   = f;
        b.accepted  = acc;
        b.last      = lst;
        return b;
    endfunction

    function automatic void run_table(t_in_item it);
        t_out_item b;
        bit        stored;
        step_beats.delete();
        if (it.action == ACT_SCHEDULE) begin
            stored = 1'b0;
            for (int s = 0; s < SLOTS && !stored; s++) begin
                if (!slot_used[s]) begin
                    slot_used[s] = 1'b1;
                    slot_wait[s] = it.delay_ms / 16'(FRAME_MS);
                    slot_trk[s]  = it.track;
                    stored = 1'b1;
                end
            end
            step_beats.push_back(beat_of(KIND_STATUS, it.track, GAIN_FULL, 8'h00, 16'h0000,
                                         stored, 1'b0));
        end else begin
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_used[s]) begin
                    if (slot_wait[s] == 16'h0000) begin
                        if (step_beats.size() + 3 <= MAX_RESULTS) begin
                            step_beats.push_back(beat_of(KIND_GAIN, slot_trk[s], GAIN_MUTE,
                                                         8'h00, 16'h0000, 1'b0, 1'b0));
                            step_beats.push_back(beat_of(KIND_PLAY, slot_trk[s], GAIN_FULL,
                                                         cur_code, 16'h0000, 1'b0, 1'b0));
                            step_beats.push_back(beat_of(KIND_FADE, slot_trk[s], GAIN_FULL,
                                                         8'h00, cur_ramp, 1'b0, 1'b0));
                            slot_used[s] = 1'b0;
                        end
                    end else begin
                        slot_wait[s] = slot_wait[s] - 16'h0001;
                    end
                end
            end
        end
        if (step_beats.size() > 0) begin
            b = step_beats.pop_back();
            b.last = 1'b1;
            step_beats.push_back(b);
        end
    endfunction

    function automatic t_plan_row plan_row(logic act, logic [15:0] trk, logic [15:0] dly,
                                           int reps, int typed, t_out_item want);
        t_plan_row r;
        r.item.action   = act;
        r.item.track    = trk;
        r.item.delay_ms = dly;
        r.reps          = reps;
        r.typed         = typed;
        r.want          = want;
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.action = ($urandom_range(0, 9) < 4) ? ACT_TICK : ACT_SCHEDULE;
        it.track  = 16'($urandom);
        case ($urandom_range(0, 24))
            0:       it.delay_ms = 16'($urandom);
            1, 2, 3: it.delay_ms = 16'($urandom_range(0, FRAME_MS - 1));
            default: it.delay_ms = 16'($urandom_range(0, 8 * FRAME_MS));
        endcase
        return it;
    endfunction

    task automatic send_beat(t_in_item it, int typed, t_out_item want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        run_table(it);
        if (typed < 0) begin
            foreach (step_beats[i]) due_q.push_back(step_beats[i]);
        end else if (typed > 0) begin
            due_q.push_back(want);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PLAY_CODE) cur_code = val[7:0];
        else cur_ramp = val;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_q.size() == 0) begin
                    $error("beat with nothing due: kind %0d track %0h", o_out_item.kind,
                           o_out_item.track_out);
                    failed = 1'b1;
                end else begin
                    head_beat = due_q.pop_front();
                    check_field("kind", 16'(head_beat.kind), 16'(o_out_item.kind));
                    check_field("track_out", head_beat.track_out, o_out_item.track_out);
                    check_field("gain", {8'h00, head_beat.gain}, {8'h00, o_out_item.gain});
                    check_field("code", {8'h00, head_beat.code}, {8'h00, o_out_item.code});
                    check_field("fade_ms", head_beat.fade_ms, o_out_item.fade_ms);
                    check_field("accepted", 16'(head_beat.accepted), 16'(o_out_item.accepted));
                    check_field("last", 16'(head_beat.last), 16'(o_out_item.last));
                end
            end
            if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            if (quiet) stall_left = 0;
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_in_item    it;
        logic [7:0]  codes [4];
        logic [15:0] ramps [4];
        int          waited;

        foreach (slot_used[s]) begin
            slot_used[s] = 1'b0;
            slot_wait[s] = 16'h0000;
            slot_trk[s]  = 16'h0000;
        end

        // empty table, registers at reset, then fill to the brim
        plan.push_back(plan_row(ACT_TICK, 16'h0000, 16'h0000, 1, 0, '0));
        plan.push_back(plan_row(ACT_SCHEDULE, 16'hFFFF, 16'h0000, 1, 1,
                                beat_of(KIND_STATUS, 16'hFFFF, GAIN_FULL, 8'h00, 16'h0000,
                                        1'b1, 1'b1)));
        plan.push_back(plan_row(ACT_SCHEDULE, 16'h0000, 16'hFFFF, 1, 1,
                                beat_of(KIND_STATUS, 16'h0000, GAIN_FULL, 8'h00, 16'h0000,
                                        1'b1, 1'b1)));
        plan.push_back(plan_row(ACT_SCHEDULE, 16'h1234, 16'(FRAME_MS - 1), 1, -1, '0));
        plan.push_back(plan_row(ACT_SCHEDULE, 16'h5678, 16'(FRAME_MS), 1, -1, '0));
        plan.push_back(plan_row(ACT_TICK, 16'hFFFF, 16'hFFFF, 1, -1, '0));
        plan.push_back(plan_row(ACT_SCHEDULE, 16'h0100, 16'h0000, SLOTS - 2, -1, '0));
        plan.push_back(plan_row(ACT_SCHEDULE, 16'hABCD, 16'h0000, 1, 1,
                                beat_of(KIND_STATUS, 16'hABCD, GAIN_FULL, 8'h00, 16'h0000,
                                        1'b0, 1'b1)));
        plan.push_back(plan_row(ACT_TICK, 16'h5A5A, 16'hA5A5, 1, -1, '0));

        codes[0] = 8'hFF;
        ramps[0] = 16'hFFFF;
        codes[1] = 8'($urandom_range(1, 254));
        ramps[1] = 16'($urandom);
        codes[2] = 8'h00;
        ramps[2] = 16'h0000;
        codes[3] = 8'($urandom_range(0, 255));
        ramps[3] = 16'($urandom);

        wait (i_rst_n);
        @(posedge i_clk);

        foreach (plan[i]) begin
            for (int k = 0; k < plan[i].reps; k++) begin
                it = plan[i].item;
                it.track = it.track + 16'(k);
                send_beat(it, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            write_reg(CFG_PLAY_CODE, {8'h00, codes[ph]});
            write_reg(CFG_RAMP_MS, ramps[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
                send_beat(rand_item(), -1, '0);
            end
        end
        i_in_valid <= 1'b0;

        waited = 0;
        while (due_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (due_q.size() != 0) begin
            $error("%0d beats never arrived", due_q.size());
            failed = 1'b1;
        end

        if (!failed) begin
            $display("[delayed_track_trigger_table] OK");
        end else begin
            $display("[delayed_track_trigger_table] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/dttt_pkg.sv
sv/dttt_div.sv
sv/dttt_table.sv
sv/delayed_track_trigger_table.sv
test/delayed_track_trigger_table_test.sv
